// ----- design/failed_login_lockout_table_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the failed login lockout table
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef FAILED_LOGIN_LOCKOUT_TABLE_UNIT_ASSERT_SVH
`define FAILED_LOGIN_LOCKOUT_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// expr must hold at every edge
`define FLLT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lockout table check failed");
// cons must hold in the same cycle as ante
`define FLLT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lockout table check failed");
// cons must hold in the cycle after ante
`define FLLT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lockout table check failed");
`else
`define FLLT_ASSERT_ALWAYS(label, expr)
`define FLLT_ASSERT_IMPL(label, ante, cons)
`define FLLT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/fllt_pkg.sv -----
// ---------------------------------------------------------------------------
// fllt_pkg
// Shared types and constants of the failed login lockout table.
// ---------------------------------------------------------------------------
package fllt_pkg;

    localparam int TIME_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int FS_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCK_SECONDS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'd1;

    localparam logic [CFG_W-1:0] LOCK_SECONDS_RST   = 17'd300;
    localparam logic [CFG_W-1:0] WINDOW_SECONDS_RST = 17'd60;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        ALU_EQ,
        ALU_SUB,
        ALU_ADD,
        ALU_LT
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_META_RD,
        ST_META,
        ST_REC_WR,
        ST_CLEAR,
        ST_ALLOC_WR,
        ST_LOCK_CMP,
        ST_SUM,
        ST_WIN,
        ST_DONE
    } state_t;

    // write strobes into the slot stores
    typedef struct packed {
        logic key;
        logic meta;
        logic ivl;
    } tbl_we_t;

endpackage

// ----- design/fllt_if.sv -----
// ---------------------------------------------------------------------------
// fllt_if
// Valid/ready channels for requests into and results out of the table.
// ---------------------------------------------------------------------------
interface fllt_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [fllt_pkg::ADDR_W-1:0]     client_address;
    logic [fllt_pkg::TIME_W-1:0]     now_seconds;

    modport source (output valid, output operation, output client_address,
                    output now_seconds, input ready);
    modport sink   (input valid, input operation, input client_address,
                    input now_seconds, output ready);
endinterface

interface fllt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          blocked;
    logic                          entry_found;
    logic                          slot_evicted;
    logic [fllt_pkg::FS_W-1:0]     failures_seen;

    modport source (output valid, output blocked, output entry_found,
                    output slot_evicted, output failures_seen, input ready);
    modport sink   (input valid, input blocked, input entry_found,
                    input slot_evicted, input failures_seen, output ready);
endinterface

// ----- design/fllt_alu.sv -----
// ---------------------------------------------------------------------------
// fllt_alu
// Shared compare / subtract / add unit used by several sequencer steps.
// ---------------------------------------------------------------------------
module fllt_alu #(
    parameter int W = 34
) (
    input  fllt_pkg::alu_op_t op,
    input  logic [W-1:0]      a,
    input  logic [W-1:0]      b,
    output logic [W-1:0]      res,
    output logic              flag
);
    import fllt_pkg::*;

    // time differences wrap at 32 bits
    logic [TIME_W-1:0] diff;

    assign diff = a[TIME_W-1:0] - b[TIME_W-1:0];

    always_comb
    begin
        res  = '0;
        flag = 1'b0;
        case (op)
            ALU_EQ:  flag = (a == b);
            ALU_SUB: res  = W'(diff);
            ALU_ADD: res  = a + b;
            ALU_LT:  flag = (a < b);
            default:
            begin
                res  = '0;
                flag = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/fllt_table.sv -----
// ---------------------------------------------------------------------------
// fllt_table
// Slot stores: keys, per-slot metadata and the interval rings, registered reads.
// ---------------------------------------------------------------------------
module fllt_table #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TRIES         = 4,
    localparam int IDX_W = $clog2(TABLE_ENTRIES),
    localparam int POS_W = $clog2(TRIES),
    localparam int FC_W  = $clog2(TRIES + 1)
) (
    input  logic                            clk,
    input  fllt_pkg::tbl_we_t               we,
    input  logic [IDX_W-1:0]                key_raddr,
    input  logic [IDX_W-1:0]                key_waddr,
    input  logic [fllt_pkg::ADDR_W-1:0]     key_wdata,
    output logic [fllt_pkg::ADDR_W-1:0]     key_rdata,
    input  logic [IDX_W-1:0]                meta_addr,
    input  logic [fllt_pkg::TIME_W-1:0]     last_wdata,
    input  logic [FC_W-1:0]                 cnt_wdata,
    input  logic [POS_W-1:0]                pos_wdata,
    input  logic                            lock_wdata,
    output logic [fllt_pkg::TIME_W-1:0]     last_rdata,
    output logic [FC_W-1:0]                 cnt_rdata,
    output logic [POS_W-1:0]                pos_rdata,
    output logic                            lock_rdata,
    input  logic [IDX_W+POS_W-1:0]          ivl_addr,
    input  logic [fllt_pkg::TIME_W-1:0]     ivl_wdata,
    output logic [fllt_pkg::TIME_W-1:0]     ivl_rdata
);
    import fllt_pkg::*;

    localparam int IVL_DEPTH = TABLE_ENTRIES * (1 << POS_W);

    logic [ADDR_W-1:0] key_mem  [TABLE_ENTRIES];
    logic [TIME_W-1:0] last_mem [TABLE_ENTRIES];
    logic [FC_W-1:0]   cnt_mem  [TABLE_ENTRIES];
    logic [POS_W-1:0]  pos_mem  [TABLE_ENTRIES];
    logic              lock_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0] ivl_mem  [IVL_DEPTH];

    logic [ADDR_W-1:0] key_rdata_reg;
    logic [TIME_W-1:0] last_rdata_reg;
    logic [FC_W-1:0]   cnt_rdata_reg;
    logic [POS_W-1:0]  pos_rdata_reg;
    logic              lock_rdata_reg;
    logic [TIME_W-1:0] ivl_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we.key)
            key_mem[key_waddr] <= key_wdata;
        key_rdata_reg <= key_mem[key_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (we.meta)
        begin
            last_mem[meta_addr] <= last_wdata;
            cnt_mem[meta_addr]  <= cnt_wdata;
            pos_mem[meta_addr]  <= pos_wdata;
            lock_mem[meta_addr] <= lock_wdata;
        end
        last_rdata_reg <= last_mem[meta_addr];
        cnt_rdata_reg  <= cnt_mem[meta_addr];
        pos_rdata_reg  <= pos_mem[meta_addr];
        lock_rdata_reg <= lock_mem[meta_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we.ivl)
            ivl_mem[ivl_addr] <= ivl_wdata;
        ivl_rdata_reg <= ivl_mem[ivl_addr];
    end

    assign key_rdata  = key_rdata_reg;
    assign last_rdata = last_rdata_reg;
    assign cnt_rdata  = cnt_rdata_reg;
    assign pos_rdata  = pos_rdata_reg;
    assign lock_rdata = lock_rdata_reg;
    assign ivl_rdata  = ivl_rdata_reg;

endmodule

// ----- design/failed_login_lockout_table_unit.sv -----
// ---------------------------------------------------------------------------
// Failed login lockout table: a key scan over the used slots, then the slot's
// metadata, interval and lock steps; one request at a time, next one taken the
// cycle after the result loads. Limited by the single shared ALU and the
// single-address metadata and interval stores. Reset empties the table (fill
// count), sets lock/window seconds to 300/60; no clearing pass.
// ---------------------------------------------------------------------------
`include "failed_login_lockout_table_unit_assert.svh"

module failed_login_lockout_table_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int TRIES         = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fllt_in_if.sink                            request,
    fllt_out_if.source                         response,
    input  logic                               cfg_we,
    input  logic [fllt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fllt_pkg::CFG_W-1:0]         cfg_data
);
    import fllt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int POS_W = $clog2(TRIES);
    localparam int FC_W  = $clog2(TRIES + 1);
    localparam int SUM_W = TIME_W + $clog2(TRIES);

    localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [FC_W-1:0]  TRIES_C   = FC_W'(TRIES);
    localparam logic [POS_W:0]   TRIES_K   = (POS_W + 1)'(TRIES);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(TRIES - 1);

    state_t            state_reg, state_next;
    logic              op_reg, op_next;
    logic [ADDR_W-1:0] key_reg, key_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [CFG_W-1:0]  lock_sec_reg, win_sec_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [IDX_W-1:0]  oldest_reg, oldest_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [POS_W:0]    k_reg, k_next;
    logic              acc_vld_reg, acc_vld_next;
    logic [SUM_W-1:0]  tmp_reg, tmp_next;
    logic [TIME_W-1:0] m_last_reg, m_last_next;
    logic [FC_W-1:0]   m_cnt_reg, m_cnt_next;
    logic [POS_W-1:0]  m_pos_reg, m_pos_next;
    logic              m_lock_reg, m_lock_next;
    logic              res_blocked_reg, res_blocked_next;
    logic              res_found_reg, res_found_next;
    logic              res_evict_reg, res_evict_next;
    logic [FC_W-1:0]   res_count_reg, res_count_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_blocked_reg, out_blocked_next;
    logic              out_found_reg, out_found_next;
    logic              out_evict_reg, out_evict_next;
    logic [FC_W-1:0]   out_count_reg, out_count_next;

    tbl_we_t           tbl_we;
    logic [IDX_W-1:0]  key_raddr;
    logic [ADDR_W-1:0] key_rdata;
    logic [TIME_W-1:0] last_wdata, last_rdata;
    logic [FC_W-1:0]   cnt_wdata, cnt_rdata;
    logic [POS_W-1:0]  pos_wdata, pos_rdata;
    logic              lock_wdata, lock_rdata;
    logic [IDX_W+POS_W-1:0] ivl_addr;
    logic [TIME_W-1:0] ivl_wdata, ivl_rdata;

    alu_op_t           alu_op;
    logic [SUM_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_flag;

    logic              issue;
    logic              load_out;

    fllt_alu #(.W(SUM_W)) u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .res  (alu_res),
        .flag (alu_flag)
    );

    fllt_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .TRIES(TRIES)) u_table (
        .clk        (clk),
        .we         (tbl_we),
        .key_raddr  (key_raddr),
        .key_waddr  (slot_reg),
        .key_wdata  (key_reg),
        .key_rdata  (key_rdata),
        .meta_addr  (slot_reg),
        .last_wdata (last_wdata),
        .cnt_wdata  (cnt_wdata),
        .pos_wdata  (pos_wdata),
        .lock_wdata (lock_wdata),
        .last_rdata (last_rdata),
        .cnt_rdata  (cnt_rdata),
        .pos_rdata  (pos_rdata),
        .lock_rdata (lock_rdata),
        .ivl_addr   (ivl_addr),
        .ivl_wdata  (ivl_wdata),
        .ivl_rdata  (ivl_rdata)
    );

    assign request.ready = (state_reg == ST_IDLE);
    assign load_out      = (state_reg == ST_DONE) && (!out_valid_reg || response.ready);

    assign response.valid         = out_valid_reg;
    assign response.blocked       = out_blocked_reg;
    assign response.entry_found   = out_found_reg;
    assign response.slot_evicted  = out_evict_reg;
    assign response.failures_seen = FS_W'(out_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_sec_reg <= LOCK_SECONDS_RST;
            win_sec_reg  <= WINDOW_SECONDS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCK_SECONDS:   lock_sec_reg <= cfg_data;
                CFG_WINDOW_SECONDS: win_sec_reg  <= cfg_data;
                default:            lock_sec_reg <= lock_sec_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            oldest_reg    <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            k_reg         <= '0;
            acc_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            oldest_reg    <= oldest_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            k_reg         <= k_next;
            acc_vld_reg   <= acc_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        cmp_idx_reg     <= cmp_idx_next;
        slot_reg        <= slot_next;
        tmp_reg         <= tmp_next;
        m_last_reg      <= m_last_next;
        m_cnt_reg       <= m_cnt_next;
        m_pos_reg       <= m_pos_next;
        m_lock_reg      <= m_lock_next;
        res_blocked_reg <= res_blocked_next;
        res_found_reg   <= res_found_next;
        res_evict_reg   <= res_evict_next;
        res_count_reg   <= res_count_next;
        out_blocked_reg <= out_blocked_next;
        out_found_reg   <= out_found_next;
        out_evict_reg   <= out_evict_next;
        out_count_reg   <= out_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        used_next        = used_reg;
        oldest_next      = oldest_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        slot_next        = slot_reg;
        k_next           = k_reg;
        acc_vld_next     = acc_vld_reg;
        tmp_next         = tmp_reg;
        m_last_next      = m_last_reg;
        m_cnt_next       = m_cnt_reg;
        m_pos_next       = m_pos_reg;
        m_lock_next      = m_lock_reg;
        res_blocked_next = res_blocked_reg;
        res_found_next   = res_found_reg;
        res_evict_next   = res_evict_reg;
        res_count_next   = res_count_reg;
        out_blocked_next = out_blocked_reg;
        out_found_next   = out_found_reg;
        out_evict_next   = out_evict_reg;
        out_count_next   = out_count_reg;
        out_valid_next   = out_valid_reg && !response.ready;

        tbl_we     = '0;
        key_raddr  = rd_idx_reg[IDX_W-1:0];
        ivl_addr   = {slot_reg, k_reg[POS_W-1:0]};
        ivl_wdata  = '0;
        last_wdata = m_last_reg;
        cnt_wdata  = m_cnt_reg;
        pos_wdata  = m_pos_reg;
        lock_wdata = m_lock_reg;
        alu_op     = ALU_EQ;
        alu_a      = SUM_W'(key_rdata);
        alu_b      = SUM_W'(key_reg);
        issue      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                begin
                    op_next          = request.operation;
                    key_next         = request.client_address;
                    now_next         = request.now_seconds;
                    rd_idx_next      = '0;
                    cmp_vld_next     = 1'b0;
                    res_blocked_next = 1'b0;
                    res_found_next   = 1'b0;
                    res_evict_next   = 1'b0;
                    res_count_next   = '0;
                    state_next       = ST_SCAN;
                end
            end

            // one key read issued per cycle, compared in the cycle after
            ST_SCAN:
            begin
                issue        = (rd_idx_reg < used_reg);
                cmp_vld_next = issue;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                rd_idx_next  = rd_idx_reg + CNT_W'(issue);
                if (cmp_vld_reg && alu_flag)
                begin
                    cmp_vld_next   = 1'b0;
                    slot_next      = cmp_idx_reg;
                    res_found_next = 1'b1;
                    state_next     = ST_META_RD;
                end
                else if (!cmp_vld_reg && !issue)
                begin
                    if (op_reg == OP_RECORD)
                    begin
                        if (used_reg < ENTRIES_C)
                        begin
                            slot_next = used_reg[IDX_W-1:0];
                            used_next = used_reg + CNT_W'(1);
                        end
                        else
                        begin
                            slot_next      = oldest_reg;
                            oldest_next    = (oldest_reg == LAST_IDX) ? '0
                                                                      : oldest_reg + IDX_W'(1);
                            res_evict_next = 1'b1;
                        end
                        k_next     = '0;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_META_RD:
            begin
                state_next = ST_META;
            end

            ST_META:
            begin
                m_last_next = last_rdata;
                m_cnt_next  = cnt_rdata;
                m_pos_next  = pos_rdata;
                m_lock_next = lock_rdata;
                alu_op      = ALU_SUB;
                alu_a       = SUM_W'(now_reg);
                alu_b       = SUM_W'(last_rdata);
                tmp_next    = alu_res;
                if (op_reg == OP_RECORD)
                begin
                    state_next = ST_REC_WR;
                end
                else if (lock_rdata)
                begin
                    state_next = ST_LOCK_CMP;
                end
                else if (cnt_rdata >= TRIES_C)
                begin
                    tmp_next     = '0;
                    k_next       = '0;
                    acc_vld_next = 1'b0;
                    state_next   = ST_SUM;
                end
                else
                begin
                    res_count_next = cnt_rdata;
                    state_next     = ST_DONE;
                end
            end

            ST_REC_WR:
            begin
                tbl_we.ivl  = 1'b1;
                tbl_we.meta = 1'b1;
                ivl_addr    = {slot_reg, m_pos_reg};
                ivl_wdata   = tmp_reg[TIME_W-1:0];
                last_wdata  = now_reg;
                pos_wdata   = (m_pos_reg == LAST_POS) ? '0 : m_pos_reg + POS_W'(1);
                cnt_wdata   = (m_cnt_reg < TRIES_C) ? m_cnt_reg + FC_W'(1) : m_cnt_reg;
                res_count_next = cnt_wdata;
                state_next  = ST_DONE;
            end

            // new slot: write the key and zero its interval ring
            ST_CLEAR:
            begin
                tbl_we.key = 1'b1;
                tbl_we.ivl = 1'b1;
                ivl_wdata  = '0;
                k_next     = k_reg + (POS_W + 1)'(1);
                if (k_reg[POS_W-1:0] == LAST_POS)
                    state_next = ST_ALLOC_WR;
            end

            ST_ALLOC_WR:
            begin
                tbl_we.meta    = 1'b1;
                last_wdata     = now_reg;
                cnt_wdata      = FC_W'(1);
                pos_wdata      = POS_W'(1);
                lock_wdata     = 1'b0;
                res_count_next = FC_W'(1);
                state_next     = ST_DONE;
            end

            ST_LOCK_CMP:
            begin
                alu_op = ALU_LT;
                alu_a  = tmp_reg;
                alu_b  = SUM_W'(lock_sec_reg);
                if (alu_flag)
                begin
                    res_blocked_next = 1'b1;
                    res_count_next   = m_cnt_reg;
                end
                else
                begin
                    // lock expired: count is cleared, so it cannot relock here
                    tbl_we.meta    = 1'b1;
                    cnt_wdata      = '0;
                    pos_wdata      = '0;
                    lock_wdata     = 1'b0;
                    res_count_next = '0;
                end
                state_next = ST_DONE;
            end

            ST_SUM:
            begin
                issue        = (k_reg < TRIES_K);
                acc_vld_next = issue;
                k_next       = k_reg + (POS_W + 1)'(issue);
                alu_op       = ALU_ADD;
                alu_a        = tmp_reg;
                alu_b        = SUM_W'(ivl_rdata);
                if (acc_vld_reg)
                    tmp_next = alu_res;
                if (!issue && !acc_vld_reg)
                    state_next = ST_WIN;
            end

            ST_WIN:
            begin
                alu_op         = ALU_LT;
                alu_a          = tmp_reg;
                alu_b          = SUM_W'(win_sec_reg);
                res_count_next = m_cnt_reg;
                if (alu_flag)
                begin
                    tbl_we.meta      = 1'b1;
                    lock_wdata       = 1'b1;
                    res_blocked_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next   = 1'b1;
                    out_blocked_next = res_blocked_reg;
                    out_found_next   = res_found_reg;
                    out_evict_next   = res_evict_reg;
                    out_count_next   = res_count_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `FLLT_ASSERT_ALWAYS(a_used_bound, used_reg <= ENTRIES_C)
    `FLLT_ASSERT_IMPL(a_oldest_only_full, oldest_reg != '0, used_reg == ENTRIES_C)
    `FLLT_ASSERT_NEXT(a_accept_scans, request.valid && request.ready, state_reg == ST_SCAN)
    `FLLT_ASSERT_IMPL(a_evict_new_entry, response.valid && response.slot_evicted,
                      !response.entry_found && !response.blocked)

endmodule
